/* src/lfpr_pkg.sv */
`timescale 1ns / 1ps

package lfpr_pkg;

    // buffer geometry
    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int BYTE_W       = 8;
    localparam int FILL_W       = 6;
    localparam int CMD_W        = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_RX    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // input item
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] rx_byte;
    } t_in_item;

    // result item
    typedef struct packed {
        logic              stored;
        logic [BYTE_W-1:0] read_byte;
        logic              read_valid;
        logic              packet_ready;
        logic              overflowed;
        logic [FILL_W-1:0] fill_level;
    } t_out_item;

endpackage

/* src/lfpr_ram.sv */
`timescale 1ns / 1ps

module lfpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* src/length_framed_packet_receiver.sv */
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_ready   lfpr_pkg::t_in_item
// out       output     o_out_valid / i_out_ready lfpr_pkg::t_out_item
// cfg       input      i_cfg_we                  i_cfg_wdata (start byte)
//
// one item per cycle while the output is not stalled; each result passes through the
// read stage, which waits for the byte store read, and then the output register.
// framing state, pointers and fill count are registers updated as the item is
// taken; the byte store is a one-port-write, one-port-read ram.
// synchronous active-low reset clears control state and flags; store contents
// stay undefined until written.
// a stalled output holds one result in the output register and one in the
// read stage; the input is held off only when both are full.

module length_framed_packet_receiver (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lfpr_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lfpr_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata
);

    logic                            r_start_seen, n_start_seen;
    logic                            r_length_seen, n_length_seen;
    logic [lfpr_pkg::BYTE_W-1:0]     r_payload_count, n_payload_count;
    logic [lfpr_pkg::BYTE_W-1:0]     r_packet_length, n_packet_length;
    logic [lfpr_pkg::ADDR_W-1:0]     r_write_ptr, n_write_ptr;
    logic [lfpr_pkg::ADDR_W-1:0]     r_read_ptr, n_read_ptr;
    logic [lfpr_pkg::ADDR_W-1:0]     r_unread, n_unread;
    logic                            r_ready_flag, n_ready_flag;
    logic                            r_overflow_flag, n_overflow_flag;
    logic [lfpr_pkg::BYTE_W-1:0]     r_start_byte;

    logic                            w_accept;
    logic                            w_s1_move;
    logic                            w_store;
    logic                            w_pop;
    logic [lfpr_pkg::BYTE_W-1:0]     w_rdata;

    logic                            r_s1_valid;
    lfpr_pkg::t_out_item             r_s1_item;
    lfpr_pkg::t_out_item             n_out_item;
    logic                            r_out_valid;
    lfpr_pkg::t_out_item             r_out_item;

    localparam logic [lfpr_pkg::ADDR_W-1:0] LAST_ADDR =
        lfpr_pkg::ADDR_W'(lfpr_pkg::BUFFER_DEPTH - 1);

    // handshake
    assign w_s1_move  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_s1_move;
    assign w_accept   = i_in_valid && o_in_ready;

    // start byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= '0;
        end else if (i_cfg_we) begin
            r_start_byte <= i_cfg_wdata;
        end
    end

    // framing, pointer and flag updates for the taken item
    always_comb begin
        n_start_seen    = r_start_seen;
        n_length_seen   = r_length_seen;
        n_payload_count = r_payload_count;
        n_packet_length = r_packet_length;
        n_write_ptr     = r_write_ptr;
        n_read_ptr      = r_read_ptr;
        n_unread        = r_unread;
        n_ready_flag    = r_ready_flag;
        n_overflow_flag = r_overflow_flag;
        w_store         = 1'b0;
        w_pop           = 1'b0;
        if (w_accept) begin
            case (i_in_item.command)
                lfpr_pkg::CMD_RX: begin
                    if (r_length_seen) begin
                        if (r_packet_length >= 8'd2 &&
                            r_payload_count < (r_packet_length - 8'd2)) begin
                            n_payload_count = r_payload_count + 8'd1;
                            w_store         = 1'b1;
                        end else begin
                            // trailing byte closes the packet
                            n_payload_count = '0;
                            n_length_seen   = 1'b0;
                            n_start_seen    = 1'b0;
                            n_ready_flag    = 1'b1;
                        end
                    end else if (r_start_seen) begin
                        n_length_seen   = 1'b1;
                        n_packet_length = i_in_item.rx_byte;
                        w_store         = 1'b1;
                    end
                    // start byte opens a packet, also right after one closes
                    if (!w_store && !n_start_seen &&
                        i_in_item.rx_byte == r_start_byte) begin
                        n_start_seen = 1'b1;
                        w_store      = 1'b1;
                    end
                end
                lfpr_pkg::CMD_POP: begin
                    if (r_unread != '0) begin
                        w_pop      = 1'b1;
                        n_read_ptr = (r_read_ptr == LAST_ADDR) ? '0 :
                                     r_read_ptr + lfpr_pkg::ADDR_W'(1);
                        n_unread   = r_unread - lfpr_pkg::ADDR_W'(1);
                    end
                end
                lfpr_pkg::CMD_CLEAR: begin
                    n_ready_flag    = 1'b0;
                    n_overflow_flag = 1'b0;
                end
                default: begin
                end
            endcase
        end
        // store advances write pointer and fill count
        if (w_store) begin
            n_write_ptr = (r_write_ptr == LAST_ADDR) ? '0 :
                          r_write_ptr + lfpr_pkg::ADDR_W'(1);
            if (r_unread == LAST_ADDR) begin
                n_unread        = '0;
                n_overflow_flag = 1'b1;
            end else begin
                n_unread = r_unread + lfpr_pkg::ADDR_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_seen    <= 1'b0;
            r_length_seen   <= 1'b0;
            r_payload_count <= '0;
            r_packet_length <= '0;
            r_write_ptr     <= '0;
            r_read_ptr      <= '0;
            r_unread        <= '0;
            r_ready_flag    <= 1'b0;
            r_overflow_flag <= 1'b0;
        end else begin
            r_start_seen    <= n_start_seen;
            r_length_seen   <= n_length_seen;
            r_payload_count <= n_payload_count;
            r_packet_length <= n_packet_length;
            r_write_ptr     <= n_write_ptr;
            r_read_ptr      <= n_read_ptr;
            r_unread        <= n_unread;
            r_ready_flag    <= n_ready_flag;
            r_overflow_flag <= n_overflow_flag;
        end
    end

    // byte store
    lfpr_ram #(
        .WIDTH (lfpr_pkg::BYTE_W),
        .DEPTH (lfpr_pkg::BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_write_ptr),
        .i_wdata (i_in_item.rx_byte),
        .i_re    (w_pop),
        .i_raddr (r_read_ptr),
        .o_rdata (w_rdata)
    );

    // read stage: waits for the store read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_item.stored       <= w_store;
            r_s1_item.read_byte    <= '0;
            r_s1_item.read_valid   <= w_pop;
            r_s1_item.packet_ready <= n_ready_flag;
            r_s1_item.overflowed   <= n_overflow_flag;
            r_s1_item.fill_level   <= lfpr_pkg::FILL_W'(n_unread);
        end
    end

    // merge popped byte into the result
    always_comb begin
        n_out_item = r_s1_item;
        n_out_item.read_byte = r_s1_item.read_valid ? w_rdata : '0;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* src/lfpr_checker.sv */
`timescale 1ns / 1ps

module lfpr_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_ready,
    input  lfpr_pkg::t_in_item   i_in_item,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  lfpr_pkg::t_out_item  o_out_item
);

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // waiting input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_item))
        else $error("waiting input item changed");

    // input is held off only behind a full output
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // fill level moves by at most one between back-to-back results
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) ##1 (o_out_valid && i_out_ready) |->
            (o_out_item.fill_level == $past(o_out_item.fill_level)) ||
            (o_out_item.fill_level ==
                lfpr_pkg::FILL_W'($past(o_out_item.fill_level) + 6'd1)) ||
            (o_out_item.fill_level ==
                lfpr_pkg::FILL_W'($past(o_out_item.fill_level) - 6'd1)))
        else $error("fill level jumped");

endmodule

bind length_framed_packet_receiver lfpr_checker u_lfpr_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam logic [lfpr_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 6;
    localparam int PHASE_ITEMS   = 250;

    // framing and ring buffer prediction plus result checking
    class frame_scoreboard;
        lfpr_pkg::t_out_item  pending_results[$];
        int         errors;
        int         n_checked, n_stored, n_popped, n_frames, n_overflows;

        logic [7:0] start_byte;
        bit         start_seen, length_seen;
        int         payload_count, packet_length;
        int         wr_ptr, rd_ptr, unread;
        bit         ready_flag, overflow_flag;
        logic [7:0] ring [lfpr_pkg::BUFFER_DEPTH];

        function new();
            start_byte = '0;
            start_seen = 0;
            length_seen = 0;
            payload_count = 0;
            packet_length = 0;
            wr_ptr = 0;
            rd_ptr = 0;
            unread = 0;
            ready_flag = 0;
            overflow_flag = 0;
        endfunction

        // true when the next received byte closes the current frame
        function bit frame_ends_next();
            return length_seen && (packet_length < 2 || payload_count >= packet_length - 2);
        endfunction

        // write one byte into the ring, wrap the count on overflow
        function void push_byte(logic [7:0] b);
            ring[wr_ptr] = b;
            wr_ptr = (wr_ptr + 1) % lfpr_pkg::BUFFER_DEPTH;
            unread++;
            n_stored++;
            if (unread >= lfpr_pkg::BUFFER_DEPTH) begin
                unread = 0;
                overflow_flag = 1;
                n_overflows++;
            end
        endfunction

        // predict the result of an accepted item; returns 1 if it stored a byte or was a pop or clear
        function bit note_accepted_item(lfpr_pkg::t_in_item req);
            lfpr_pkg::t_out_item res;
            res = '0;
            case (req.command)
                lfpr_pkg::CMD_RX: begin
                    if (length_seen) begin
                        if (frame_ends_next()) begin
                            payload_count = 0;
                            length_seen = 0;
                            start_seen = 0;
                            ready_flag = 1;
                            n_frames++;
                        end else begin
                            payload_count = (payload_count + 1) & 8'hFF;
                            push_byte(req.rx_byte);
                            res.stored = 1'b1;
                        end
                    end else if (start_seen) begin
                        length_seen = 1;
                        packet_length = int'(req.rx_byte);
                        push_byte(req.rx_byte);
                        res.stored = 1'b1;
                    end
                    // a closing byte equal to the start byte opens the next frame
                    if (!res.stored && !start_seen && req.rx_byte == start_byte) begin
                        start_seen = 1;
                        push_byte(req.rx_byte);
                        res.stored = 1'b1;
                    end
                end
                lfpr_pkg::CMD_POP: begin
                    if (unread > 0) begin
                        res.read_byte = ring[rd_ptr];
                        res.read_valid = 1'b1;
                        rd_ptr = (rd_ptr + 1) % lfpr_pkg::BUFFER_DEPTH;
                        unread--;
                        n_popped++;
                    end
                end
                lfpr_pkg::CMD_CLEAR: begin
                    ready_flag = 0;
                    overflow_flag = 0;
                end
                default: ;
            endcase
            res.packet_ready = ready_flag;
            res.overflowed = overflow_flag;
            res.fill_level = unread[lfpr_pkg::FILL_W-1:0];
            pending_results.push_back(res);
            return res.stored || req.command == lfpr_pkg::CMD_POP ||
                   req.command == lfpr_pkg::CMD_CLEAR;
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                errors++;
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
            end
        endfunction

        function void check_result(lfpr_pkg::t_out_item got);
            lfpr_pkg::t_out_item want;
            if (pending_results.size() == 0) begin
                errors++;
                $error("result with no item waiting: %h", got);
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            compare_field("stored", 8'(want.stored), 8'(got.stored));
            compare_field("read_byte", want.read_byte, got.read_byte);
            compare_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
            compare_field("packet_ready", 8'(want.packet_ready), 8'(got.packet_ready));
            compare_field("overflowed", 8'(want.overflowed), 8'(got.overflowed));
            compare_field("fill_level", 8'(want.fill_level), 8'(got.fill_level));
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    lfpr_pkg::t_in_item   in_item;
    logic       out_valid;
    logic       out_ready;
    lfpr_pkg::t_out_item  out_item;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    frame_scoreboard tracker = new();
    bit  idle_en;
    int  useful_items;
    int  n_sent;
    int  n_settings;
    int  cycle_count;

    length_framed_packet_receiver dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // result checking on each output handshake
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result(out_item);
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 2);
        else if (roll < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // output side stalls
    initial begin
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
                if (idle_en && $urandom_range(0, 4) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // present one item and hold it until taken
    task automatic send_item(input logic [lfpr_pkg::CMD_W-1:0] cmd, input logic [7:0] b);
        lfpr_pkg::t_in_item req;
        req.command = cmd;
        req.rx_byte = b;
        in_item  <= req;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        n_sent++;
        if (tracker.note_accepted_item(req))
            useful_items++;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat (pick_gap()) @(posedge clk);
        end
    endtask

    // stop sending and let every expected result come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_start_byte(input logic [7:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.start_byte = value;
        n_settings++;
    endtask

    // one frame with random content, pops mixed in
    task automatic send_packet(input int pop_pct);
        int         roll;
        logic [7:0] len;
        logic [7:0] b;
        if (!tracker.start_seen)
            send_item(lfpr_pkg::CMD_RX, tracker.start_byte);
        if (tracker.start_seen && !tracker.length_seen) begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                len = 8'($urandom_range(0, 10));
            else if (roll < 95)
                len = 8'($urandom_range(11, 40));
            else
                len = 8'($urandom_range(41, 255));
            send_item(lfpr_pkg::CMD_RX, len);
        end
        while (tracker.length_seen) begin
            if ($urandom_range(0, 99) < pop_pct)
                send_item(lfpr_pkg::CMD_POP, 8'($urandom));
            b = 8'($urandom);
            if (tracker.frame_ends_next() && $urandom_range(0, 2) == 0)
                b = tracker.start_byte;
            send_item(lfpr_pkg::CMD_RX, b);
        end
    endtask

    task automatic run_random_phase(input logic [7:0] start_value);
        int goal;
        int pop_pct;
        int roll;
        goal = n_sent + PHASE_ITEMS;
        pop_pct = $urandom_range(30, 55);
        write_start_byte(start_value);
        idle_en = 1'b0;
        while (n_sent < goal) begin
            // quiet stretch at the start of each phase and now and then
            idle_en = (n_sent > goal - PHASE_ITEMS + 40) && ($urandom_range(0, 9) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                send_packet(pop_pct);
            end else if (roll < 80) begin
                repeat ($urandom_range(1, 8)) send_item(lfpr_pkg::CMD_POP, 8'($urandom));
            end else if (roll < 88) begin
                send_item(lfpr_pkg::CMD_CLEAR, 8'($urandom));
            end else if (roll < 96) begin
                repeat ($urandom_range(1, 4)) send_item(lfpr_pkg::CMD_RX, 8'($urandom));
            end else begin
                send_item(CMD_UNUSED, 8'($urandom));
            end
        end
        drain_results();
    endtask

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        idle_en   = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items
        write_start_byte(8'h7E);
        send_item(lfpr_pkg::CMD_RX, 8'h00);       // dropped outside a frame
        send_item(lfpr_pkg::CMD_POP, 8'hFF);      // pop on empty buffer
        send_item(CMD_UNUSED, 8'h00);
        send_item(lfpr_pkg::CMD_RX, 8'h7E);
        send_item(lfpr_pkg::CMD_RX, 8'h04);
        send_item(lfpr_pkg::CMD_RX, 8'h11);
        send_item(lfpr_pkg::CMD_RX, 8'h22);
        send_item(lfpr_pkg::CMD_RX, 8'h55);       // closes frame, not stored
        send_item(lfpr_pkg::CMD_RX, 8'h7E);
        send_item(lfpr_pkg::CMD_RX, 8'h01);       // short length
        send_item(lfpr_pkg::CMD_RX, 8'h7E);       // closes and reopens
        send_item(lfpr_pkg::CMD_RX, 8'h00);       // zero length
        send_item(lfpr_pkg::CMD_RX, 8'hFF);
        send_item(lfpr_pkg::CMD_RX, 8'h7E);
        send_item(lfpr_pkg::CMD_RX, 8'h02);
        send_item(lfpr_pkg::CMD_RX, 8'h33);
        send_item(lfpr_pkg::CMD_POP, 8'h00);
        send_item(lfpr_pkg::CMD_POP, 8'h00);
        send_item(lfpr_pkg::CMD_POP, 8'h00);
        send_item(lfpr_pkg::CMD_CLEAR, 8'h00);
        send_item(CMD_UNUSED, 8'hFF);
        drain_results();

        // random phases over several start bytes, extremes included
        run_random_phase(8'h00);
        run_random_phase(8'hFF);
        run_random_phase(8'($urandom));
        run_random_phase(8'($urandom));
        run_random_phase(8'h7E);

        $display("ran %0d items (%0d working), %0d results checked, %0d start byte settings",
                 n_sent, useful_items, tracker.n_checked, n_settings);
        $display("%0d bytes buffered, %0d popped, %0d frames closed, %0d overflows",
                 tracker.n_stored, tracker.n_popped, tracker.n_frames, tracker.n_overflows);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
